/* rtl/bdr_pkg.sv */
// Types and constants shared by the barrel distortion remap core.
// Depends on nothing; the top level takes everything here by scoped name.
`default_nettype none

package bdr_pkg;

   localparam int COORD_W = 9;
   localparam int SQ_W    = 17;
   localparam int K_W     = 32;
   localparam int PROD_W  = 49;
   localparam int SUM_W   = 50;
   localparam int SPLIT_W = 25;
   localparam int LO_W    = 35;
   localparam int HI_W    = 34;
   localparam int P_W     = 60;
   localparam int FRAC_W  = 32;
   localparam int RND_W   = P_W - FRAC_W;
   localparam int PIX_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_K_ROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_COL = 2'd1;

   typedef struct packed {
      logic             func;
      logic [7:0]       row;
      logic [7:0]       col;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             out_of_range;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/barrel_distortion_remap_core.sv */
// Radial lens distortion correction remap over a stored source frame; uses bdr_pkg.
// A read transaction's result passes through the stage registers and the store read register to rsp_data.
// Throughput: one transaction per cycle; the whole pipeline holds while a result stalls.
// Reset (synchronous, active high) clears the valid bits and both coefficients;
// the frame store is not cleared and holds garbage until written.
`default_nettype none

module barrel_distortion_remap_core #(
   parameter int OUT_ROWS = 64,
   parameter int OUT_COLS = 128,
   parameter int SRC_ROWS = 60,
   parameter int SRC_COLS = 80
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  bdr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output bdr_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [bdr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [bdr_pkg::K_W-1:0]              csr_wdata
);

   localparam int DEPTH  = SRC_ROWS * SRC_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [bdr_pkg::COORD_W-1:0] X_OFF = bdr_pkg::COORD_W'(OUT_ROWS / 2);
   localparam logic [bdr_pkg::COORD_W-1:0] Y_OFF = bdr_pkg::COORD_W'(OUT_COLS / 2);
   localparam logic [bdr_pkg::RND_W:0] ROW_CTR = (bdr_pkg::RND_W + 1)'(SRC_ROWS / 2);
   localparam logic [bdr_pkg::RND_W:0] COL_CTR = (bdr_pkg::RND_W + 1)'(SRC_COLS / 2);

   logic signed [bdr_pkg::K_W-1:0] k_row_ff, k_col_ff;
   logic adv;
   logic [7:1] vld_ff;
   logic rsp_valid_ff;

   // carried fields per stage
   logic [6:1] func_ff;
   logic [7:0] row_ff [6:1];
   logic [7:0] col_ff [6:1];
   logic [bdr_pkg::PIX_W-1:0] pix_ff [7:1];

   logic signed [bdr_pkg::COORD_W-1:0] x_ff [4:1];
   logic signed [bdr_pkg::COORD_W-1:0] y_ff [4:1];

   // stage 1
   logic signed [bdr_pkg::COORD_W-1:0] x_in, y_in;
   logic signed [2*bdr_pkg::COORD_W-1:0] x_sq_full, y_sq_full;
   logic [bdr_pkg::SQ_W-1:0] x_sq_ff, y_sq_ff;
   // stage 2
   logic signed [bdr_pkg::PROD_W-1:0] prod_row_in, prod_col_in, prod_row_ff, prod_col_ff;
   // stage 3
   logic signed [bdr_pkg::SUM_W-1:0] sum_in, sum_ff;
   // stage 4
   logic signed [bdr_pkg::LO_W-1:0] lo_row_in, lo_col_in, lo_row_ff, lo_col_ff;
   logic signed [bdr_pkg::HI_W-1:0] hi_row_in, hi_col_in, hi_row_ff, hi_col_ff;
   logic signed [bdr_pkg::SPLIT_W:0] sum_lo;
   logic signed [bdr_pkg::SPLIT_W-1:0] sum_hi;
   // stage 5
   logic signed [bdr_pkg::P_W-1:0] p_row_in, p_col_in, p_row_ff, p_col_ff;
   // stage 6
   logic signed [bdr_pkg::P_W-1:0] bias_row, bias_col;
   logic signed [bdr_pkg::RND_W-1:0] r_row_ff, r_col_ff;
   // stage 7
   logic [bdr_pkg::RND_W:0] sr, sc;
   logic rd_in_frame, wr_in_frame, oor_in;
   logic [7:0] idx_row_in, idx_col_in, idx_row_ff, idx_col_ff;
   logic oor_ff, func7_ff;
   // store and output
   logic [16:0] addr_full;
   logic [ADDR_W-1:0] addr;
   logic [bdr_pkg::PIX_W-1:0] frame_ff [DEPTH];
   logic [bdr_pkg::PIX_W-1:0] rd_ff;
   logic rsp_oor_ff;

   // hold the pipeline and the store while a result waits
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_row_ff <= '0;
         k_col_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdr_pkg::CSR_K_ROW: k_row_ff <= $signed(csr_wdata);
            bdr_pkg::CSR_K_COL: k_col_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[6:1], req_valid};
         rsp_valid_ff <= vld_ff[7] && (func7_ff == bdr_pkg::FUNC_READ);
      end
   end

   // stage 1: centre and square
   assign x_in      = $signed({1'b0, req_data.row} - X_OFF);
   assign y_in      = $signed({1'b0, req_data.col} - Y_OFF);
   assign x_sq_full = x_in * x_in;
   assign y_sq_full = y_in * y_in;

   // stage 2: coefficient products
   assign prod_row_in = $signed(k_row_ff) * $signed({1'b0, x_sq_ff});
   assign prod_col_in = $signed(k_col_ff) * $signed({1'b0, y_sq_ff});

   // stage 3: scale offset
   assign sum_in = {prod_row_ff[bdr_pkg::PROD_W-1], prod_row_ff}
                 + {prod_col_ff[bdr_pkg::PROD_W-1], prod_col_ff};

   // stage 4: partial products of coordinate by offset
   assign sum_lo    = $signed({1'b0, sum_ff[bdr_pkg::SPLIT_W-1:0]});
   assign sum_hi    = sum_ff[bdr_pkg::SUM_W-1:bdr_pkg::SPLIT_W];
   assign lo_row_in = x_ff[3] * sum_lo;
   assign lo_col_in = y_ff[3] * sum_lo;
   assign hi_row_in = x_ff[3] * sum_hi;
   assign hi_col_in = y_ff[3] * sum_hi;

   // stage 5: coordinate times scale, 32 fraction bits
   assign p_row_in =
        {{(bdr_pkg::P_W-bdr_pkg::COORD_W-bdr_pkg::FRAC_W){x_ff[4][bdr_pkg::COORD_W-1]}},
         x_ff[4], {bdr_pkg::FRAC_W{1'b0}}}
      + {{(bdr_pkg::P_W-bdr_pkg::HI_W-bdr_pkg::SPLIT_W){hi_row_ff[bdr_pkg::HI_W-1]}},
         hi_row_ff, {bdr_pkg::SPLIT_W{1'b0}}}
      + {{(bdr_pkg::P_W-bdr_pkg::LO_W){lo_row_ff[bdr_pkg::LO_W-1]}}, lo_row_ff};
   assign p_col_in =
        {{(bdr_pkg::P_W-bdr_pkg::COORD_W-bdr_pkg::FRAC_W){y_ff[4][bdr_pkg::COORD_W-1]}},
         y_ff[4], {bdr_pkg::FRAC_W{1'b0}}}
      + {{(bdr_pkg::P_W-bdr_pkg::HI_W-bdr_pkg::SPLIT_W){hi_col_ff[bdr_pkg::HI_W-1]}},
         hi_col_ff, {bdr_pkg::SPLIT_W{1'b0}}}
      + {{(bdr_pkg::P_W-bdr_pkg::LO_W){lo_col_ff[bdr_pkg::LO_W-1]}}, lo_col_ff};

   // stage 6: round half away from zero, one less bias below zero
   assign bias_row = p_row_ff + $signed({{(bdr_pkg::P_W-bdr_pkg::FRAC_W){1'b0}}, 1'b1,
                                         {(bdr_pkg::FRAC_W-1){1'b0}}})
                   - $signed({{(bdr_pkg::P_W-1){1'b0}}, p_row_ff[bdr_pkg::P_W-1]});
   assign bias_col = p_col_ff + $signed({{(bdr_pkg::P_W-bdr_pkg::FRAC_W){1'b0}}, 1'b1,
                                         {(bdr_pkg::FRAC_W-1){1'b0}}})
                   - $signed({{(bdr_pkg::P_W-1){1'b0}}, p_col_ff[bdr_pkg::P_W-1]});

   // stage 7: source centre, frame check, pick store index
   assign sr = {r_row_ff[bdr_pkg::RND_W-1], r_row_ff} + ROW_CTR;
   assign sc = {r_col_ff[bdr_pkg::RND_W-1], r_col_ff} + COL_CTR;
   assign rd_in_frame = !sr[bdr_pkg::RND_W] && !sc[bdr_pkg::RND_W]
                     && (sr[bdr_pkg::RND_W-1:0] < bdr_pkg::RND_W'(SRC_ROWS))
                     && (sc[bdr_pkg::RND_W-1:0] < bdr_pkg::RND_W'(SRC_COLS));
   assign wr_in_frame = ({1'b0, row_ff[6]} < 9'(SRC_ROWS))
                     && ({1'b0, col_ff[6]} < 9'(SRC_COLS));

   always_comb begin
      oor_in     = 1'b1;
      idx_row_in = '0;
      idx_col_in = '0;
      case (func_ff[6])
         bdr_pkg::FUNC_READ: begin
            oor_in = !rd_in_frame;
            if (rd_in_frame) begin
               idx_row_in = sr[7:0];
               idx_col_in = sc[7:0];
            end
         end
         default: begin
            oor_in = !wr_in_frame;
            if (wr_in_frame) begin
               idx_row_in = row_ff[6];
               idx_col_in = col_ff[6];
            end
         end
      endcase
   end

   // store access
   assign addr_full = 17'(idx_row_ff) * 17'(SRC_COLS) + 17'(idx_col_ff);
   assign addr      = addr_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         func_ff   <= {func_ff[5:1], req_data.func};
         row_ff[1] <= req_data.row;
         col_ff[1] <= req_data.col;
         pix_ff[1] <= req_data.pixel_in;
         for (int i = 2; i <= 6; i++) begin
            row_ff[i] <= row_ff[i-1];
            col_ff[i] <= col_ff[i-1];
         end
         for (int i = 2; i <= 7; i++) begin
            pix_ff[i] <= pix_ff[i-1];
         end
         x_ff[1] <= x_in;
         y_ff[1] <= y_in;
         for (int i = 2; i <= 4; i++) begin
            x_ff[i] <= x_ff[i-1];
            y_ff[i] <= y_ff[i-1];
         end
         x_sq_ff     <= x_sq_full[bdr_pkg::SQ_W-1:0];
         y_sq_ff     <= y_sq_full[bdr_pkg::SQ_W-1:0];
         prod_row_ff <= prod_row_in;
         prod_col_ff <= prod_col_in;
         sum_ff      <= sum_in;
         lo_row_ff   <= lo_row_in;
         lo_col_ff   <= lo_col_in;
         hi_row_ff   <= hi_row_in;
         hi_col_ff   <= hi_col_in;
         p_row_ff    <= p_row_in;
         p_col_ff    <= p_col_in;
         r_row_ff    <= bias_row[bdr_pkg::P_W-1:bdr_pkg::FRAC_W];
         r_col_ff    <= bias_col[bdr_pkg::P_W-1:bdr_pkg::FRAC_W];
         idx_row_ff  <= idx_row_in;
         idx_col_ff  <= idx_col_in;
         oor_ff      <= oor_in;
         func7_ff    <= func_ff[6];
         rsp_oor_ff  <= oor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (vld_ff[7] && (func7_ff == bdr_pkg::FUNC_WRITE) && !oor_ff) begin
            frame_ff[addr] <= pix_ff[7];
         end
         rd_ff <= frame_ff[addr];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.pixel_out     = rsp_oor_ff ? '0 : rd_ff;
   assign rsp_data.out_of_range  = rsp_oor_ff;

`ifndef NO_ASSERTIONS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(vld_ff) && $stable(rsp_oor_ff)))
      else $error("pipeline moved while result stalled");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[7] && !oor_ff) |->
         (({1'b0, idx_row_ff} < 9'(SRC_ROWS)) && ({1'b0, idx_col_ff} < 9'(SRC_COLS))))
      else $error("store index outside frame");

   a_result_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[7] && (func7_ff == bdr_pkg::FUNC_READ)))
      else $error("result without a read transaction");
`endif

endmodule

`default_nettype wire
